// File: src/shpd_pkg.sv
`timescale 1ns / 1ps
package shpd_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned OpW   = 16;
  localparam int unsigned FormW = 8;
  localparam int unsigned OpvW  = 11;

  typedef enum logic [2:0] {
    FLOW_SEQ    = 3'd0,
    FLOW_BRANCH = 3'd1,
    FLOW_CALL   = 3'd2,
    FLOW_RETURN = 3'd3,
    FLOW_TRAP   = 3'd4
  } flow_e;

  typedef enum logic [1:0] {
    LIT_NONE = 2'd0,
    LIT_WORD = 2'd1,
    LIT_LONG = 2'd2,
    LIT_MOVA = 2'd3
  } lit_e;

  // group 3 low nibble to form number, zero for unassigned codes
  function automatic logic [FormW-1:0] grp3_form(input logic [3:0] lo);
    logic [FormW-1:0] f;
    begin
      f = '0;
      case (lo)
        4'h0: f = 8'd99;
        4'h2: f = 8'd100;
        4'h3: f = 8'd101;
        4'h4: f = 8'd102;
        4'h6: f = 8'd103;
        4'h7: f = 8'd104;
        4'h8: f = 8'd105;
        4'hA: f = 8'd106;
        4'hB: f = 8'd107;
        4'hC: f = 8'd108;
        4'hE: f = 8'd109;
        4'hF: f = 8'd110;
        default: f = '0;
      endcase
      return f;
    end
  endfunction

endpackage

// File: src/sh1_opcode_predecoder_top.sv
`timescale 1ns / 1ps
// Path: an accepted input beat passes the input register, then the result register,
// before it leaves as a result beat.
// Throughput: one opcode per cycle unless out_stall_i holds a waiting result; the decode and
// the address adders sit between the input register and the result register.
// Reset: asynchronous, active low; clears both valid flags, no other state.
module sh1_opcode_predecoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [shpd_pkg::AddrW-1:0]   instruction_address_i,
  input  logic [shpd_pkg::OpW-1:0]     opcode_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [shpd_pkg::FormW-1:0]   form_id_o,
  output logic [3:0]                   reg_n_o,
  output logic [3:0]                   reg_m_o,
  output logic signed [shpd_pkg::OpvW-1:0] operand_value_o,
  output logic                         is_illegal_o,
  output logic [2:0]                   flow_class_o,
  output logic                         has_delay_slot_o,
  output logic                         is_conditional_o,
  output logic                         has_target_o,
  output logic [shpd_pkg::AddrW-1:0]   target_address_o,
  output logic [1:0]                   literal_kind_o,
  output logic [shpd_pkg::AddrW-1:0]   literal_address_o
);
  import shpd_pkg::*;

  logic             iv_q;
  logic [AddrW-1:0] addr_q;
  logic [OpW-1:0]   op_q;
  logic             ov_q;
  logic             adv;

  // advance the pipe when the result slot is free or being taken
  assign adv        = !ov_q || !out_stall_i;
  assign in_stall_o = iv_q && !adv;

  // hold the input beat until the result register takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (!in_stall_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      addr_q <= instruction_address_i;
      op_q   <= opcode_word_i;
    end
  end

  // decode
  logic [3:0]       n, m, lo, hi;
  logic [7:0]       imm;
  logic [FormW-1:0] form;
  logic             un, um, ds, cond, tv;
  flow_e            flow;
  lit_e             lkind;
  logic signed [OpvW-1:0] opv;
  logic [AddrW-1:0] tgt, laddr, pc4, apc4;
  logic [AddrW-1:0] d8, d12, imm2, imm4;

  always_comb begin
    hi   = op_q[15:12];
    n    = op_q[11:8];
    m    = op_q[7:4];
    lo   = op_q[3:0];
    imm  = op_q[7:0];
    pc4  = addr_q + 32'd4;
    apc4 = {addr_q[AddrW-1:2], 2'b00} + 32'd4;
    d8   = {{(AddrW-9){imm[7]}}, imm, 1'b0};
    d12  = {{(AddrW-13){op_q[11]}}, op_q[11:0], 1'b0};
    imm2 = {{(AddrW-9){1'b0}}, imm, 1'b0};
    imm4 = {{(AddrW-10){1'b0}}, imm, 2'b00};
    form = '0; un = 1'b0; um = 1'b0; ds = 1'b0; cond = 1'b0; tv = 1'b0;
    flow = FLOW_SEQ; lkind = LIT_NONE; opv = '0; tgt = '0; laddr = '0;
    unique case (hi)
      4'h0: begin
        case (lo)
          4'h2: if (m < 4'd3) begin form = 8'd1 + 8'(m); un = 1'b1; end
          4'h4, 4'h5, 4'h6: begin
            form = 8'd4 + 8'(lo - 4'd4); un = 1'b1; um = 1'b1;
          end
          4'h8: if (n == 4'd0 && m < 4'd3) form = 8'd7 + 8'(m);
          4'h9: begin
            if (m == 4'd0 && n == 4'd0) form = 8'd10;
            else if (m == 4'd1 && n == 4'd0) form = 8'd11;
            else if (m == 4'd2) begin form = 8'd12; un = 1'b1; end
          end
          4'hA: if (m < 4'd3) begin form = 8'd13 + 8'(m); un = 1'b1; end
          4'hB: if (n == 4'd0 && m < 4'd3) begin
            form = 8'd16 + 8'(m);
            if (m != 4'd1) begin flow = FLOW_RETURN; ds = 1'b1; end
          end
          4'hC, 4'hD, 4'hE: begin
            form = 8'd19 + 8'(lo - 4'hC); un = 1'b1; um = 1'b1;
          end
          default: ;
        endcase
      end
      4'h4: begin
        un = 1'b1;
        case (lo)
          4'h0: if (m == 4'd0) form = 8'd22; else if (m == 4'd2) form = 8'd23;
          4'h4: if (m == 4'd0) form = 8'd33; else if (m == 4'd2) form = 8'd34;
          4'h1, 4'h2, 4'h3: if (m < 4'd3) form = 8'd24 + 8'(3*(lo-1)) + 8'(m);
          4'h5, 4'h6, 4'h7, 4'h8, 4'h9, 4'hA:
            if (m < 4'd3) form = 8'd35 + 8'(3*(lo-5)) + 8'(m);
          4'hB: if (m < 4'd3) begin
            form = 8'd53 + 8'(m);
            if (m == 4'd0) begin flow = FLOW_CALL; ds = 1'b1; end
            else if (m == 4'd2) begin flow = FLOW_BRANCH; ds = 1'b1; end
          end
          4'hE: if (m < 4'd3) form = 8'd56 + 8'(m);
          4'hF: begin form = 8'd59; um = 1'b1; end
          default: ;
        endcase
      end
      4'h8: begin
        case (n)
          4'h0: begin form = 8'd60; um = 1'b1; opv = OpvW'(lo); end
          4'h1: begin form = 8'd61; um = 1'b1; opv = OpvW'({lo, 1'b0}); end
          4'h4: begin form = 8'd62; um = 1'b1; opv = OpvW'(lo); end
          4'h5: begin form = 8'd63; um = 1'b1; opv = OpvW'({lo, 1'b0}); end
          4'h8: begin form = 8'd64; opv = OpvW'(signed'(imm)); end
          4'h9, 4'hB: begin
            form = (n == 4'h9) ? 8'd65 : 8'd66;
            flow = FLOW_BRANCH; cond = 1'b1; tv = 1'b1;
            tgt  = pc4 + d8;
          end
          default: ;
        endcase
      end
      4'hC: begin
        form = 8'd67 + 8'(n);
        if (n == 4'd1 || n == 4'd5) opv = OpvW'({imm, 1'b0});
        else if (n == 4'd2 || n == 4'd6 || n == 4'd7) opv = OpvW'({imm, 2'b00});
        else opv = OpvW'(imm);
        if (n == 4'd3) flow = FLOW_TRAP;
        if (n == 4'd7) begin lkind = LIT_MOVA; laddr = apc4 + imm4; end
      end
      4'h1: begin form = 8'd83; un = 1'b1; um = 1'b1; opv = OpvW'({lo, 2'b00}); end
      4'h2: begin
        if (lo < 4'd3) form = 8'd84 + 8'(lo);
        else if (lo > 4'd3) form = 8'd87 + 8'(lo - 4'd4);
        un = 1'b1; um = 1'b1;
      end
      4'h3: begin form = grp3_form(lo); un = 1'b1; um = 1'b1; end
      4'h5: begin form = 8'd111; un = 1'b1; um = 1'b1; opv = OpvW'({lo, 2'b00}); end
      4'h6: begin form = 8'd112 + 8'(lo); un = 1'b1; um = 1'b1; end
      4'h7: begin form = 8'd128; un = 1'b1; opv = OpvW'(signed'(imm)); end
      4'h9: begin
        form = 8'd129; un = 1'b1; opv = OpvW'({imm, 1'b0});
        lkind = LIT_WORD; laddr = pc4 + imm2;
      end
      4'hA, 4'hB: begin
        form = (hi == 4'hA) ? 8'd130 : 8'd131;
        flow = (hi == 4'hA) ? FLOW_BRANCH : FLOW_CALL;
        ds = 1'b1; tv = 1'b1;
        tgt = pc4 + d12;
      end
      4'hD: begin
        form = 8'd132; un = 1'b1; opv = OpvW'({imm, 2'b00});
        lkind = LIT_LONG; laddr = apc4 + imm4;
      end
      4'hE: begin form = 8'd133; un = 1'b1; opv = OpvW'(signed'(imm)); end
      default: ;
    endcase
    // drop everything for an illegal code
    if (form == '0) begin
      un = 1'b0; um = 1'b0; opv = '0; flow = FLOW_SEQ; ds = 1'b0; cond = 1'b0;
      tv = 1'b0; tgt = '0; lkind = LIT_NONE; laddr = '0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && iv_q) begin
      form_id_o         <= form;
      reg_n_o           <= un ? n : 4'd0;
      reg_m_o           <= um ? m : 4'd0;
      operand_value_o   <= opv;
      is_illegal_o      <= (form == '0);
      flow_class_o      <= flow;
      has_delay_slot_o  <= ds;
      is_conditional_o  <= cond;
      has_target_o      <= tv;
      target_address_o  <= tgt;
      literal_kind_o    <= lkind;
      literal_address_o <= laddr;
    end
  end

  assign out_valid_o = ov_q;

  // a stalled result must hold its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(form_id_o))
    else $error("result beat changed under stall");
  // illegal flag matches the form code
  a_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_illegal_o == (form_id_o == '0)))
    else $error("illegal flag disagrees with form");
  // conditional branches carry targets and have no delay slot
  a_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_conditional_o |-> has_target_o && !has_delay_slot_o)
    else $error("conditional branch marks inconsistent");
  // input stalls only while a beat waits behind a stalled result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without back-pressure");

endmodule
